// ===== hdl/lras_pkg.sv =====
// Shared types and constants of the LED-ring animation sequencer.
package lras_pkg;

    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_LISTEN = 3'd1;
    localparam logic [2:0] M_SPEAK  = 3'd2;
    localparam logic [2:0] M_MUTE   = 3'd3;
    localparam logic [2:0] M_UNMUTE = 3'd4;
    localparam logic [2:0] M_OFF    = 3'd5;

    localparam logic [2:0] P_START = 3'd0;
    localparam logic [2:0] P_PRE   = 3'd1;
    localparam logic [2:0] P_UP    = 3'd2;
    localparam logic [2:0] P_DOWN  = 3'd3;
    localparam logic [2:0] P_POST  = 3'd4;
    localparam logic [2:0] P_LIT   = 3'd5;
    localparam logic [2:0] P_DARK  = 3'd6;

    localparam logic [1:0] A_PIXEL   = 2'd0;
    localparam logic [1:0] A_CLEAR   = 2'd1;
    localparam logic [1:0] A_REFRESH = 2'd2;

    localparam logic [2:0] R_IDLE_RGB   = 3'd0;
    localparam logic [2:0] R_LISTEN_RGB = 3'd1;
    localparam logic [2:0] R_SPEAK_RGB  = 3'd2;
    localparam logic [2:0] R_MUTE_RGB   = 3'd3;
    localparam logic [2:0] R_UNMUTE_RGB = 3'd4;
    localparam logic [2:0] R_PEAK       = 3'd5;
    localparam logic [2:0] R_ENABLES    = 3'd6;
    localparam logic [2:0] R_RING_SIZE  = 3'd7;

    localparam logic [11:0] IDLE_PRE_MS   = 12'd2000;
    localparam logic [11:0] IDLE_STEP_MS  = 12'd100;
    localparam logic [11:0] IDLE_POST_MS  = 12'd3000;
    localparam logic [11:0] LISTEN_MS     = 12'd80;
    localparam logic [11:0] SPEAK_STEP_MS = 12'd20;
    localparam logic [11:0] SPEAK_POST_MS = 12'd200;
    localparam logic [11:0] TRANS_STEP_MS = 12'd50;

    typedef enum logic [1:0] {
        SEL_NEW,
        SEL_SAME,
        SEL_IDLE
    } ent_sel_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_TICK_DEC,
        DP_ENTER,
        DP_SET_PRE,
        DP_GROUP0,
        DP_OFF_CLR,
        DP_PRE_CLR,
        DP_MOD_STEP,
        DP_START_UP,
        DP_START_DOWN,
        DP_UP_STEP,
        DP_DOWN_STEP,
        DP_SCALE,
        DP_PIX_IDLE,
        DP_PIX_ALL,
        DP_PAINT_REF,
        DP_FIN_BLACK,
        DP_FIN_CLR,
        DP_FIN_REF,
        DP_LIT,
        DP_DARK,
        DP_LP_SCALE,
        DP_LP_PIX,
        DP_LP_REF,
        DP_FLUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t   op;
        ent_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic       op_set;
        logic       mode_diff;
        logic       cleared;
        logic [2:0] mode;
        logic [2:0] phase;
        logic       wait_zero;
        logic       disabled;
        logic       peak_zero;
        logic       up_ok;
        logic       down_ok;
        logic       pix_left;
        logic       lp_left;
        logic       k_zero;
        logic       can_emit;
        logic       p_valid;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== hdl/lras_datapath.sv =====
// Datapath: configuration, animation state, color scaling and result buffering.
module lras_datapath #(
    parameter int MAX_LEDS   = 32,
    parameter int RAMP_STEPS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lras_pkg::dp_cmd_t  cmd,
    output lras_pkg::dp_status_t st,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [23:0]        cfg_wdata,
    input  logic               in_op,
    input  logic [2:0]         in_new_mode,
    input  logic [7:0]         in_random_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_action,
    output logic [4:0]         out_pixel_index,
    output logic [23:0]        out_pixel_rgb,
    output logic               out_last
);
    import lras_pkg::*;

    localparam int RECIP = (65536 + RAMP_STEPS - 1) / RAMP_STEPS;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

    logic [23:0] idle_rgb_reg, listen_rgb_reg, speak_rgb_reg, mute_rgb_reg, unmute_rgb_reg;
    logic [7:0]  peak_reg;
    logic [4:0]  en_reg;
    logic [5:0]  ring_reg;

    logic [2:0]  mode_reg, mode_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  level_reg, level_next;
    logic [11:0] wait_reg, wait_next;
    logic [4:0]  chosen_reg, chosen_next;
    logic [1:0]  group_reg, group_next;
    logic        cleared_reg, cleared_next;
    logic        op_reg;
    logic [2:0]  newm_reg;
    logic [7:0]  rnd_reg;
    logic [23:0] rgb_reg, rgb_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [7:0]  rem_reg, rem_next;
    logic [2:0]  k_reg, k_next;

    logic        p_valid_reg, p_valid_next;
    logic [1:0]  p_act_reg, p_act_next;
    logic [4:0]  p_idx_reg, p_idx_next;
    logic [23:0] p_rgb_reg, p_rgb_next;
    logic        o_valid_reg, o_valid_next;
    logic [1:0]  o_act_reg, o_act_next;
    logic [4:0]  o_idx_reg, o_idx_next;
    logic [23:0] o_rgb_reg, o_rgb_next;
    logic        o_last_reg, o_last_next;

    logic [5:0]  n;
    logic [24:0] step_prod;
    logic [7:0]  step;
    logic [8:0]  up_nxt;
    logic [2:0]  newm_clamp;
    logic [7:0]  en_ext;
    logic [23:0] sc_col;
    logic [7:0]  sc_lvl;
    logic [15:0] pr, pg, pb;
    logic [23:0] sc_rgb;
    logic [11:0] step_ms;
    logic [13:0] sub_val;
    logic        emit;
    logic [1:0]  e_act;
    logic [4:0]  e_idx;
    logic [23:0] e_rgb;
    logic        out_free;

    always_comb
    begin
        if (ring_reg == 6'd0)
            n = 6'd1;
        else if ({26'd0, ring_reg} > MAX_LEDS)
            n = 6'(MAX_LEDS);
        else
            n = ring_reg;
    end

    assign step_prod  = {17'd0, peak_reg} * 25'(RECIP);
    assign step       = (step_prod[23:16] == 8'd0) ? 8'd1 : step_prod[23:16];
    assign up_nxt     = {1'b0, level_reg} + {1'b0, step};
    assign newm_clamp = (newm_reg > M_OFF) ? M_OFF : newm_reg;
    assign en_ext     = {3'd0, en_reg};

    always_comb
    begin
        if (cmd.op == DP_LP_SCALE)
        begin
            sc_col = listen_rgb_reg;
            sc_lvl = peak_reg;
        end
        else
        begin
            sc_lvl = level_reg;
            case (mode_reg)
                M_IDLE:  sc_col = idle_rgb_reg;
                M_SPEAK: sc_col = speak_rgb_reg;
                M_MUTE:  sc_col = mute_rgb_reg;
                default: sc_col = unmute_rgb_reg;
            endcase
        end
    end

    assign pr = {8'd0, sc_col[23:16]} * {8'd0, sc_lvl};
    assign pg = {8'd0, sc_col[15:8]} * {8'd0, sc_lvl};
    assign pb = {8'd0, sc_col[7:0]} * {8'd0, sc_lvl};
    assign sc_rgb = {div255(pr), div255(pg), div255(pb)};

    always_comb
    begin
        case (mode_reg)
            M_IDLE:  step_ms = IDLE_STEP_MS;
            M_SPEAK: step_ms = SPEAK_STEP_MS;
            default: step_ms = TRANS_STEP_MS;
        endcase
    end

    // restoring remainder: one shifted compare-subtract per cycle
    assign sub_val = {8'd0, n} << k_reg;

    always_comb
    begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        level_next   = level_reg;
        wait_next    = wait_reg;
        chosen_next  = chosen_reg;
        group_next   = group_reg;
        cleared_next = cleared_reg;
        rgb_next     = rgb_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        k_next       = k_reg;
        emit         = 1'b0;
        e_act        = A_PIXEL;
        e_idx        = 5'd0;
        e_rgb        = 24'd0;
        case (cmd.op)
            DP_TICK_DEC:
            begin
                if (wait_reg != 12'd0)
                    wait_next = wait_reg - 12'd1;
            end
            DP_ENTER:
            begin
                case (cmd.sel)
                    SEL_NEW:  mode_next = newm_clamp;
                    SEL_IDLE: mode_next = M_IDLE;
                    default:  mode_next = mode_reg;
                endcase
                cleared_next = 1'b0;
                wait_next    = 12'd0;
                phase_next   = P_START;
            end
            DP_SET_PRE:
            begin
                phase_next = P_PRE;
                wait_next  = IDLE_PRE_MS;
            end
            DP_GROUP0:
                group_next = 2'd0;
            DP_OFF_CLR:
            begin
                emit         = 1'b1;
                e_act        = A_CLEAR;
                cleared_next = 1'b1;
            end
            DP_PRE_CLR:
            begin
                emit     = 1'b1;
                e_act    = A_CLEAR;
                rem_next = rnd_reg;
                k_next   = 3'd7;
            end
            DP_MOD_STEP:
            begin
                if ({6'd0, rem_reg} >= sub_val)
                    rem_next = rem_reg - sub_val[7:0];
                k_next = k_reg - 3'd1;
                if (k_reg == 3'd0)
                    chosen_next = rem_next[4:0];
            end
            DP_START_UP:
            begin
                level_next = 8'd0;
                phase_next = P_UP;
            end
            DP_START_DOWN:
            begin
                level_next = peak_reg;
                phase_next = P_DOWN;
            end
            DP_UP_STEP:
            begin
                if (up_nxt < {1'b0, peak_reg})
                    level_next = up_nxt[7:0];
            end
            DP_DOWN_STEP:
            begin
                if (level_reg > step)
                    level_next = level_reg - step;
            end
            DP_SCALE, DP_LP_SCALE:
            begin
                rgb_next = sc_rgb;
                cnt_next = 6'd0;
            end
            DP_PIX_IDLE:
            begin
                emit  = 1'b1;
                e_idx = chosen_reg;
                e_rgb = rgb_reg;
            end
            DP_PIX_ALL:
            begin
                emit     = 1'b1;
                e_idx    = cnt_reg[4:0];
                e_rgb    = rgb_reg;
                cnt_next = cnt_reg + 6'd1;
            end
            DP_PAINT_REF:
            begin
                emit      = 1'b1;
                e_act     = A_REFRESH;
                wait_next = step_ms;
            end
            DP_FIN_BLACK:
            begin
                emit  = 1'b1;
                e_idx = chosen_reg;
            end
            DP_FIN_CLR:
            begin
                emit  = 1'b1;
                e_act = A_CLEAR;
            end
            DP_FIN_REF:
            begin
                emit       = 1'b1;
                e_act      = A_REFRESH;
                phase_next = P_POST;
                wait_next  = (mode_reg == M_IDLE) ? IDLE_POST_MS : SPEAK_POST_MS;
            end
            DP_LIT:
            begin
                emit       = 1'b1;
                e_act      = A_CLEAR;
                phase_next = P_DARK;
                wait_next  = LISTEN_MS;
            end
            DP_DARK:
                group_next = (group_reg >= 2'd2) ? 2'd0 : group_reg + 2'd1;
            DP_LP_PIX:
            begin
                emit     = 1'b1;
                e_idx    = cnt_reg[4:0] + {3'd0, group_reg};
                e_rgb    = rgb_reg;
                cnt_next = cnt_reg + 6'd3;
            end
            DP_LP_REF:
            begin
                emit       = 1'b1;
                e_act      = A_REFRESH;
                phase_next = P_LIT;
                wait_next  = LISTEN_MS;
            end
            default:
            begin
            end
        endcase
    end

    assign out_free = !o_valid_reg || out_ready;

    always_comb
    begin
        p_valid_next = p_valid_reg;
        p_act_next   = p_act_reg;
        p_idx_next   = p_idx_reg;
        p_rgb_next   = p_rgb_reg;
        o_valid_next = o_valid_reg && !out_ready;
        o_act_next   = o_act_reg;
        o_idx_next   = o_idx_reg;
        o_rgb_next   = o_rgb_reg;
        o_last_next  = o_last_reg;
        if (emit)
        begin
            if (p_valid_reg)
            begin
                o_valid_next = 1'b1;
                o_act_next   = p_act_reg;
                o_idx_next   = p_idx_reg;
                o_rgb_next   = p_rgb_reg;
                o_last_next  = 1'b0;
            end
            p_valid_next = 1'b1;
            p_act_next   = e_act;
            p_idx_next   = e_idx;
            p_rgb_next   = e_rgb;
        end
        else if (cmd.op == DP_FLUSH)
        begin
            o_valid_next = 1'b1;
            o_act_next   = p_act_reg;
            o_idx_next   = p_idx_reg;
            o_rgb_next   = p_rgb_reg;
            o_last_next  = 1'b1;
            p_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_rgb_reg   <= 24'd0;
            listen_rgb_reg <= 24'd0;
            speak_rgb_reg  <= 24'd0;
            mute_rgb_reg   <= 24'd0;
            unmute_rgb_reg <= 24'd0;
            peak_reg       <= 8'd255;
            en_reg         <= 5'd31;
            ring_reg       <= 6'd12;
            mode_reg       <= M_UNMUTE;
            phase_reg      <= P_START;
            level_reg      <= 8'd0;
            wait_reg       <= 12'd0;
            chosen_reg     <= 5'd0;
            group_reg      <= 2'd0;
            cleared_reg    <= 1'b0;
            p_valid_reg    <= 1'b0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    R_IDLE_RGB:   idle_rgb_reg   <= cfg_wdata;
                    R_LISTEN_RGB: listen_rgb_reg <= cfg_wdata;
                    R_SPEAK_RGB:  speak_rgb_reg  <= cfg_wdata;
                    R_MUTE_RGB:   mute_rgb_reg   <= cfg_wdata;
                    R_UNMUTE_RGB: unmute_rgb_reg <= cfg_wdata;
                    R_PEAK:       peak_reg       <= cfg_wdata[7:0];
                    R_ENABLES:    en_reg         <= cfg_wdata[4:0];
                    R_RING_SIZE:  ring_reg       <= cfg_wdata[5:0];
                    default:      ;
                endcase
            end
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            level_reg   <= level_next;
            wait_reg    <= wait_next;
            chosen_reg  <= chosen_next;
            group_reg   <= group_next;
            cleared_reg <= cleared_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LATCH)
        begin
            op_reg   <= in_op;
            newm_reg <= in_new_mode;
            rnd_reg  <= in_random_value;
        end
        rgb_reg    <= rgb_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        k_reg      <= k_next;
        p_act_reg  <= p_act_next;
        p_idx_reg  <= p_idx_next;
        p_rgb_reg  <= p_rgb_next;
        o_act_reg  <= o_act_next;
        o_idx_reg  <= o_idx_next;
        o_rgb_reg  <= o_rgb_next;
        o_last_reg <= o_last_next;
    end

    assign st.op_set    = op_reg;
    assign st.mode_diff = newm_clamp != mode_reg;
    assign st.cleared   = cleared_reg;
    assign st.mode      = mode_reg;
    assign st.phase     = phase_reg;
    assign st.wait_zero = wait_reg == 12'd0;
    assign st.disabled  = (mode_reg >= M_OFF) || !en_ext[mode_reg];
    assign st.peak_zero = peak_reg == 8'd0;
    assign st.up_ok     = up_nxt < {1'b0, peak_reg};
    assign st.down_ok   = level_reg > step;
    assign st.pix_left  = cnt_reg < n;
    assign st.lp_left   = ({1'b0, cnt_reg} + 7'd3) <= {1'b0, n};
    assign st.k_zero    = k_reg == 3'd0;
    assign st.can_emit  = !p_valid_reg || out_free;
    assign st.p_valid   = p_valid_reg;
    assign st.out_free  = out_free;

    assign out_valid       = o_valid_reg;
    assign out_action      = o_act_reg;
    assign out_pixel_index = o_idx_reg;
    assign out_pixel_rgb   = o_rgb_reg;
    assign out_last        = o_last_reg;

endmodule

// ===== hdl/lras_ctrl.sv =====
// Controller: sequences the animation steps of one input word.
module lras_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lras_pkg::dp_status_t st,
    output lras_pkg::dp_cmd_t    cmd
);
    import lras_pkg::*;

    typedef enum logic [24:0] {
        C_WAIT       = 25'h0000001,
        C_DECODE     = 25'h0000002,
        C_PHASE      = 25'h0000004,
        C_ENTER      = 25'h0000008,
        C_ENTER_CHK  = 25'h0000010,
        C_OFF_CLR    = 25'h0000020,
        C_PRE_CLR    = 25'h0000040,
        C_MOD        = 25'h0000080,
        C_START_UP   = 25'h0000100,
        C_START_DOWN = 25'h0000200,
        C_UP_STEP    = 25'h0000400,
        C_DOWN_STEP  = 25'h0000800,
        C_SCALE      = 25'h0001000,
        C_PIX_IDLE   = 25'h0002000,
        C_PIX_ALL    = 25'h0004000,
        C_PAINT_REF  = 25'h0008000,
        C_FINISH     = 25'h0010000,
        C_FIN_REF    = 25'h0020000,
        C_LIT        = 25'h0040000,
        C_LP_SCALE   = 25'h0080000,
        C_LP_PIX     = 25'h0100000,
        C_LP_REF     = 25'h0200000,
        C_FLUSH      = 25'h0400000,
        C_DARK       = 25'h0800000,
        C_POST       = 25'h1000000
    } ctl_state_t;

    ctl_state_t state_reg, state_next;
    ent_sel_t   sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd.op     = DP_NOP;
        cmd.sel    = sel_reg;
        case (state_reg)
            C_WAIT:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = C_DECODE;
                end
            end
            C_DECODE:
            begin
                if (st.op_set)
                begin
                    sel_next   = SEL_NEW;
                    state_next = st.mode_diff ? C_ENTER : C_FLUSH;
                end
                else if (st.cleared)
                    state_next = C_FLUSH;
                else if (st.phase == P_START)
                begin
                    sel_next   = SEL_SAME;
                    state_next = C_ENTER;
                end
                else
                begin
                    cmd.op     = DP_TICK_DEC;
                    state_next = C_PHASE;
                end
            end
            C_PHASE:
            begin
                if (!st.wait_zero)
                    state_next = C_FLUSH;
                else
                begin
                    case (st.phase)
                        P_PRE:  state_next = C_PRE_CLR;
                        P_UP:   state_next = C_UP_STEP;
                        P_DOWN: state_next = C_DOWN_STEP;
                        P_POST: state_next = C_POST;
                        P_LIT:  state_next = C_LIT;
                        P_DARK: state_next = C_DARK;
                        default:
                        begin
                            sel_next   = SEL_SAME;
                            state_next = C_ENTER;
                        end
                    endcase
                end
            end
            C_POST:
            begin
                if (st.mode == M_IDLE)
                begin
                    cmd.op     = DP_SET_PRE;
                    state_next = C_FLUSH;
                end
                else if (st.mode == M_SPEAK)
                    state_next = C_START_UP;
                else
                begin
                    sel_next   = SEL_SAME;
                    state_next = C_ENTER;
                end
            end
            C_ENTER:
            begin
                cmd.op     = DP_ENTER;
                state_next = C_ENTER_CHK;
            end
            C_ENTER_CHK:
            begin
                if (st.disabled)
                    state_next = C_OFF_CLR;
                else if (st.mode == M_IDLE)
                begin
                    cmd.op     = DP_SET_PRE;
                    state_next = C_FLUSH;
                end
                else if (st.mode == M_LISTEN)
                begin
                    cmd.op     = DP_GROUP0;
                    state_next = C_LP_SCALE;
                end
                else
                    state_next = C_START_UP;
            end
            C_OFF_CLR:
            begin
                if (st.can_emit)
                begin
                    cmd.op     = DP_OFF_CLR;
                    state_next = C_FLUSH;
                end
            end
            C_PRE_CLR:
            begin
                if (st.can_emit)
                begin
                    cmd.op     = DP_PRE_CLR;
                    state_next = C_MOD;
                end
            end
            C_MOD:
            begin
                cmd.op = DP_MOD_STEP;
                if (st.k_zero)
                    state_next = C_START_UP;
            end
            C_START_UP:
            begin
                cmd.op     = DP_START_UP;
                state_next = st.peak_zero ? C_START_DOWN : C_SCALE;
            end
            C_START_DOWN:
            begin
                cmd.op     = DP_START_DOWN;
                state_next = st.peak_zero ? C_FINISH : C_SCALE;
            end
            C_UP_STEP:
            begin
                cmd.op     = DP_UP_STEP;
                state_next = st.up_ok ? C_SCALE : C_START_DOWN;
            end
            C_DOWN_STEP:
            begin
                cmd.op     = DP_DOWN_STEP;
                state_next = st.down_ok ? C_SCALE : C_FINISH;
            end
            C_SCALE:
            begin
                cmd.op     = DP_SCALE;
                state_next = (st.mode == M_IDLE) ? C_PIX_IDLE : C_PIX_ALL;
            end
            C_PIX_IDLE:
            begin
                if (st.can_emit)
                begin
                    cmd.op     = DP_PIX_IDLE;
                    state_next = C_PAINT_REF;
                end
            end
            C_PIX_ALL:
            begin
                if (!st.pix_left)
                    state_next = C_PAINT_REF;
                else if (st.can_emit)
                    cmd.op = DP_PIX_ALL;
            end
            C_PAINT_REF:
            begin
                if (st.can_emit)
                begin
                    cmd.op     = DP_PAINT_REF;
                    state_next = C_FLUSH;
                end
            end
            C_FINISH:
            begin
                if (st.mode == M_IDLE)
                begin
                    if (st.can_emit)
                    begin
                        cmd.op     = DP_FIN_BLACK;
                        state_next = C_FIN_REF;
                    end
                end
                else if (st.mode == M_SPEAK)
                begin
                    if (st.can_emit)
                    begin
                        cmd.op     = DP_FIN_CLR;
                        state_next = C_FIN_REF;
                    end
                end
                else
                begin
                    sel_next   = SEL_IDLE;
                    state_next = C_ENTER;
                end
            end
            C_FIN_REF:
            begin
                if (st.can_emit)
                begin
                    cmd.op     = DP_FIN_REF;
                    state_next = C_FLUSH;
                end
            end
            C_LIT:
            begin
                if (st.can_emit)
                begin
                    cmd.op     = DP_LIT;
                    state_next = C_FLUSH;
                end
            end
            C_DARK:
            begin
                cmd.op     = DP_DARK;
                state_next = C_LP_SCALE;
            end
            C_LP_SCALE:
            begin
                cmd.op     = DP_LP_SCALE;
                state_next = C_LP_PIX;
            end
            C_LP_PIX:
            begin
                if (!st.lp_left)
                    state_next = C_LP_REF;
                else if (st.can_emit)
                    cmd.op = DP_LP_PIX;
            end
            C_LP_REF:
            begin
                if (st.can_emit)
                begin
                    cmd.op     = DP_LP_REF;
                    state_next = C_FLUSH;
                end
            end
            C_FLUSH:
            begin
                if (!st.p_valid)
                    state_next = C_WAIT;
                else if (st.out_free)
                begin
                    cmd.op     = DP_FLUSH;
                    state_next = C_WAIT;
                end
            end
            default:
                state_next = C_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_WAIT;
            sel_reg   <= SEL_SAME;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign in_ready = state_reg == C_WAIT;

endmodule

// ===== hdl/led_ring_animation_sequencer_top.sv =====
// LED-ring animation sequencer top level.
//
// Input stream (s_*): one word is a 1 ms tick (s_tuser = 0) or a mode command
// (s_tuser = 1, mode in s_tdata). Each word yields zero to max(ring_size+1, 3)
// output words on m_* (ring_size taken as 1 to MAX_LEDS): pixel write,
// clear-all or refresh, m_tlast on the final one of that input word.
// Configuration: cfg_we writes register cfg_addr with cfg_wdata; the user
// must write only while the block is idle, which the block does not enforce.
// Flow: a word is taken when s_tready is high; the controller then steps
// through its sequencing states, and an idle pick also runs the remainder
// unit. One word is processed at a time; s_tready is high only between
// words, once the last result has moved into the output register.
// A stalled receiver (m_tready low) holds the output register and the
// controller waits on the one-word pending buffer behind it.
// Reset: asynchronous, active low; configuration and state registers take their
// defaults, mode is unmute and the first tick starts its animation.
module led_ring_animation_sequencer_top #(
    parameter int MAX_LEDS   = 32,
    parameter int RAMP_STEPS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // new_mode[2:0], random_value[10:3], zero pad
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_index[4:0], pixel_rgb[28:5], zero pad
    output logic [1:0]  m_tuser,   // action[1:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);
    import lras_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;
    logic [4:0]  pix_idx;
    logic [23:0] pix_rgb;

    lras_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lras_datapath #(
        .MAX_LEDS   (MAX_LEDS),
        .RAMP_STEPS (RAMP_STEPS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_op           (s_tuser[0]),
        .in_new_mode     (s_tdata[2:0]),
        .in_random_value (s_tdata[10:3]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_action      (m_tuser),
        .out_pixel_index (pix_idx),
        .out_pixel_rgb   (pix_rgb),
        .out_last        (m_tlast)
    );

    assign m_tdata = {3'd0, pix_rgb, pix_idx};

    a_no_pending_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !st.p_valid)
        else $error("pending word left over between input words");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        st.mode <= M_OFF)
        else $error("mode out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                     $stable(m_tuser) && $stable(m_tlast)))
        else $error("output word changed while stalled");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the LED-ring animation sequencer top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lras_pkg::*;

    localparam int LIMIT = 6000000;

    typedef struct {
        logic [1:0]  action;
        logic [4:0]  idx;
        logic [23:0] rgb;
        logic        last;
    } led_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [23:0] cfg_wdata;

    led_ring_animation_sequencer_top uut (.*);

    // shadow registers and animation state
    int unsigned rgb_reg [5];
    int unsigned peak_reg, en_reg, ring_reg;
    int unsigned cur_mode, cur_phase, cur_level, cur_wait, cur_led, cur_group, cur_cleared;
    int          word_cnt;

    led_word_t   pending_words[$];
    int          errors, checked, cycles, words_sent;
    bit          idle_on;
    int          hold_reqs, hold_served;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic void push_word(logic [1:0] a, int unsigned i, int unsigned c);
        led_word_t w;
        if (word_cnt >= 33)
            return;
        w.action = a;
        w.idx = i[4:0];
        w.rgb = c[23:0];
        w.last = 0;
        pending_words.push_back(w);
        word_cnt++;
    endfunction

    function automatic int unsigned dim(int unsigned c, int unsigned lv);
        int unsigned r, g, b;
        r = ((c >> 16) & 8'hFF) * lv / 255;
        g = ((c >> 8) & 8'hFF) * lv / 255;
        b = (c & 8'hFF) * lv / 255;
        return (r << 16) | (g << 8) | b;
    endfunction

    function automatic int unsigned leds();
        if (ring_reg == 0)
            return 1;
        if (ring_reg > 32)
            return 32;
        return ring_reg;
    endfunction

    function automatic int unsigned ramp_inc();
        return (peak_reg / 10 == 0) ? 1 : peak_reg / 10;
    endfunction

    function automatic void paint_level();
        int unsigned c;
        c = (cur_mode == M_IDLE) ? rgb_reg[0] : (cur_mode == M_SPEAK) ? rgb_reg[2] :
            (cur_mode == M_MUTE) ? rgb_reg[3] : rgb_reg[4];
        c = dim(c, cur_level);
        if (cur_mode == M_IDLE)
            push_word(A_PIXEL, cur_led, c);
        else
            for (int j = 0; j < leds(); j++)
                push_word(A_PIXEL, j, c);
        push_word(A_REFRESH, 0, 0);
        cur_wait = (cur_mode == M_IDLE) ? 100 : (cur_mode == M_SPEAK) ? 20 : 50;
    endfunction

    function automatic void paint_group();
        int unsigned c;
        c = dim(rgb_reg[1], peak_reg);
        for (int g = 0; g < leds() / 3; g++)
            push_word(A_PIXEL, g * 3 + cur_group, c);
        push_word(A_REFRESH, 0, 0);
        cur_phase = P_LIT;
        cur_wait = 80;
    endfunction

    function automatic void end_ramp();
        if (cur_mode == M_IDLE)
        begin
            push_word(A_PIXEL, cur_led, 0);
            push_word(A_REFRESH, 0, 0);
            cur_phase = P_POST;
            cur_wait = 3000;
        end
        else if (cur_mode == M_SPEAK)
        begin
            push_word(A_CLEAR, 0, 0);
            push_word(A_REFRESH, 0, 0);
            cur_phase = P_POST;
            cur_wait = 200;
        end
        else
            enter_mode(M_IDLE);
    endfunction

    function automatic void ramp_down();
        cur_level = peak_reg;
        cur_phase = P_DOWN;
        if (cur_level > 0)
            paint_level();
        else
            end_ramp();
    endfunction

    function automatic void ramp_up();
        cur_level = 0;
        cur_phase = P_UP;
        if (peak_reg > 0)
            paint_level();
        else
            ramp_down();
    endfunction

    function automatic void enter_mode(int unsigned m);
        cur_mode = m;
        cur_cleared = 0;
        cur_wait = 0;
        cur_phase = P_START;
        if (m >= M_OFF || ((en_reg >> m) & 1) == 0)
        begin
            push_word(A_CLEAR, 0, 0);
            cur_cleared = 1;
        end
        else if (m == M_IDLE)
        begin
            cur_phase = P_PRE;
            cur_wait = 2000;
        end
        else if (m == M_LISTEN)
        begin
            cur_group = 0;
            paint_group();
        end
        else
            ramp_up();
    endfunction

    function automatic void tick_step(int unsigned rnd);
        int unsigned nxt;
        if (cur_cleared)
            return;
        if (cur_phase == P_START)
        begin
            enter_mode(cur_mode);
            return;
        end
        if (cur_wait > 0)
            cur_wait--;
        if (cur_wait != 0)
            return;
        case (cur_phase)
            P_PRE:
            begin
                push_word(A_CLEAR, 0, 0);
                cur_led = rnd % leds();
                ramp_up();
            end
            P_UP:
            begin
                nxt = cur_level + ramp_inc();
                if (nxt < peak_reg)
                begin
                    cur_level = nxt;
                    paint_level();
                end
                else
                    ramp_down();
            end
            P_DOWN:
                if (cur_level > ramp_inc())
                begin
                    cur_level -= ramp_inc();
                    paint_level();
                end
                else
                    end_ramp();
            P_POST:
                if (cur_mode == M_IDLE)
                begin
                    cur_phase = P_PRE;
                    cur_wait = 2000;
                end
                else if (cur_mode == M_SPEAK)
                    ramp_up();
                else
                    enter_mode(cur_mode);
            P_LIT:
            begin
                push_word(A_CLEAR, 0, 0);
                cur_phase = P_DARK;
                cur_wait = 80;
            end
            P_DARK:
            begin
                cur_group = (cur_group >= 2) ? 0 : cur_group + 1;
                paint_group();
            end
            default:
                enter_mode(cur_mode);
        endcase
    endfunction

    function automatic void predict_word(bit op, int unsigned m, int unsigned rnd);
        word_cnt = 0;
        if (op)
        begin
            if (m > M_OFF)
                m = M_OFF;
            if (m != cur_mode)
                enter_mode(m);
        end
        else
            tick_step(rnd);
        if (word_cnt > 0)
            pending_words[$].last = 1;
    endfunction

    // one input word; valid stays high unless a gap is drawn
    task automatic send_word(bit op, logic [2:0] m, logic [7:0] rnd);
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {5'b0, rnd, m};
        do
            @(posedge clk);
        while (!s_tready);
        predict_word(op, m, rnd);
        words_sent++;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic ticks(int n);
        for (int i = 0; i < n; i++)
            send_word(0, 3'($urandom_range(0, 7)), 8'($urandom));
    endtask

    task automatic settle();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_reg(logic [2:0] a, int unsigned v);
        cfg_we <= 1;
        cfg_addr <= a;
        cfg_wdata <= v[23:0];
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        case (a)
            R_PEAK:      peak_reg = v & 8'hFF;
            R_ENABLES:   en_reg = v & 5'h1F;
            R_RING_SIZE: ring_reg = v & 6'h3F;
            default:     rgb_reg[a] = v & 24'hFFFFFF;
        endcase
    endtask

    // receiver: random short stalls plus requested long hold
    int hold_left;
    always @(posedge clk)
    begin
        if (hold_reqs != hold_served)
        begin
            hold_served <= hold_reqs;
            hold_left <= 400;
            m_tready <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            hold_left <= $urandom_range(0, 3);
            m_tready <= 0;
        end
        else
            m_tready <= 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: act=%0d idx=%0d rgb=%06h last=%0b",
                             m_tuser, m_tdata[4:0], m_tdata[28:5], m_tlast);
            end
            else
            begin
                led_word_t w;
                w = pending_words.pop_front();
                checked++;
                if (w.action !== m_tuser || w.idx !== m_tdata[4:0] ||
                    w.rgb !== m_tdata[28:5] || w.last !== m_tlast)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp act=%0d idx=%0d rgb=%06h last=%0b, got act=%0d idx=%0d rgb=%06h last=%0b",
                                 w.action, w.idx, w.rgb, w.last, m_tuser, m_tdata[4:0],
                                 m_tdata[28:5], m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("led_ring_animation_sequencer_top verification failed");
            $finish;
        end
    end

    task automatic test_power_up_unmute();
        set_reg(R_UNMUTE_RGB, 24'hFFFFFF);
        set_reg(R_PEAK, 20);
        set_reg(R_RING_SIZE, 5);
        send_word(1, M_UNMUTE, 8'hFF);
        ticks(3);
        settle();
    endtask

    task automatic test_idle();
        set_reg(R_IDLE_RGB, 24'h80FF01);
        set_reg(R_PEAK, 1);
        set_reg(R_RING_SIZE, 40);
        send_word(1, M_IDLE, 0);
        ticks(8);
        settle();
        set_reg(R_PEAK, 0);
        ticks(3);
        settle();
    endtask

    task automatic test_listen();
        set_reg(R_LISTEN_RGB, 24'h123456);
        set_reg(R_PEAK, 255);
        set_reg(R_RING_SIZE, 32);
        send_word(1, M_LISTEN, 8'h00);
        send_word(1, M_LISTEN, 8'h00);
        ticks(82);
        settle();
        set_reg(R_RING_SIZE, 2);
        send_word(1, M_IDLE, 8'hAA);
        send_word(1, M_LISTEN, 8'h55);
        ticks(3);
        settle();
    endtask

    task automatic test_speak_and_mute();
        set_reg(R_SPEAK_RGB, 24'hFEFEFE);
        set_reg(R_MUTE_RGB, 24'h00FF00);
        set_reg(R_RING_SIZE, 0);
        set_reg(R_PEAK, 255);
        send_word(1, M_SPEAK, 0);
        ticks(21);
        settle();
        set_reg(R_PEAK, 0);
        send_word(1, M_MUTE, 0);
        send_word(1, M_SPEAK, 0);
        ticks(5);
        send_word(1, M_UNMUTE, 0);
        settle();
    endtask

    task automatic test_disabled();
        set_reg(R_ENABLES, 0);
        set_reg(R_PEAK, 100);
        for (int m = 0; m < 8; m++)
        begin
            send_word(1, 3'(m), 8'($urandom));
            ticks(1);
        end
        settle();
        set_reg(R_ENABLES, 31);
        ticks(3);
        settle();
    endtask

    task automatic test_backpressure();
        set_reg(R_RING_SIZE, 32);
        set_reg(R_PEAK, 60);
        send_word(1, M_SPEAK, 0);
        hold_reqs++;
        ticks(21);
        settle();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_word(1, 3'($urandom_range(0, 7)), 8'($urandom));
            else
                ticks($urandom_range(1, 4));
        end
        settle();
    endtask

    task automatic random_config(bit extreme);
        for (int r = 0; r < 5; r++)
            set_reg(3'(r), extreme ? ($urandom_range(0, 1) ? 24'hFFFFFF : 0) : $urandom);
        set_reg(R_PEAK, extreme ? 255 : $urandom_range(1, 40));
        set_reg(R_ENABLES, $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : 31);
        set_reg(R_RING_SIZE, extreme ? 32 : $urandom_range(0, 63));
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        cfg_we = 0;
        cfg_addr = 0;
        cfg_wdata = 0;
        idle_on = 1;
        rgb_reg = '{default: 0};
        peak_reg = 255;
        en_reg = 31;
        ring_reg = 12;
        cur_mode = M_UNMUTE;
        cur_phase = P_START;
        cur_level = 0;
        cur_wait = 0;
        cur_led = 0;
        cur_group = 0;
        cur_cleared = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        test_power_up_unmute();
        test_idle();
        test_listen();
        test_speak_and_mute();
        test_disabled();
        test_backpressure();
        random_config(0);
        test_random(7);
        random_config(1);
        test_random(7);
        idle_on = 0;
        random_config(0);
        test_random(7);

        $display("%0d input words sent, %0d output words checked", words_sent, checked);
        $display("every mode entry, listen blink, disabled entry, ring and peak extremes, long output stall");
        if (errors == 0)
            $display("led_ring_animation_sequencer_top verification clean");
        else
            $display("led_ring_animation_sequencer_top verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/lras_pkg.sv
hdl/lras_datapath.sv
hdl/lras_ctrl.sv
hdl/led_ring_animation_sequencer_top.sv
verif/tb.sv
